/* hdl/rpmc_pkg.sv */
// rpmc_pkg: shared widths, codes, state and broadcast types for the
// methylation pileup block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rpmc_pkg;

  // field widths
  localparam int SITE_W     = 28;
  localparam int WLEN_W     = 7;
  localparam int LEN_W      = 6;
  localparam int PAT_POS    = 32;
  localparam int PAT_W      = 2 * PAT_POS;
  localparam int CNT_IN_W   = 24;
  localparam int OUT_CNT_W  = 32;
  localparam int IDX_OUT_W  = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 28;
  // window-relative start offset; accepted reads fall in -31 .. 63 with the default parameters
  localparam int BASE_W     = 8;

  // register reset values
  localparam logic [SITE_W-1:0] FIRST_SITE_RST = SITE_W'(1);
  localparam logic [WLEN_W-1:0] WINDOW_LEN_RST = WLEN_W'(64);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_SITE = 1'b0,
    CFG_WINDOW_LEN = 1'b1
  } cfg_idx_e;

  // pattern position codes
  typedef enum logic [1:0] {
    CODE_OTHER = 2'd0,
    CODE_T     = 2'd1,
    CODE_C     = 2'd2
  } code_e;

  // dump sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_e;

  // read broadcast from the input stage to every cell
  typedef struct packed {
    logic                          valid;
    logic signed [BASE_W-1:0]      base;
    logic [LEN_W-1:0]              len;
    logic [PAT_POS-1:0][1:0]       pattern;
    logic [CNT_IN_W-1:0]           count;
  } rd_bcast_t;

endpackage

`default_nettype wire

/* hdl/rpmc_in_if.sv */
// rpmc_in_if: valid/ready channel carrying read and dump items.
// Depends on rpmc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rpmc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [rpmc_pkg::SITE_W-1:0]    read_site;
  logic [rpmc_pkg::LEN_W-1:0]     read_span;
  logic [rpmc_pkg::PAT_W-1:0]     pattern_codes;
  logic [rpmc_pkg::CNT_IN_W-1:0]  read_count;

  modport source (
    output valid, kind, read_site, read_span, pattern_codes, read_count,
    input  ready
  );
  modport sink (
    input  valid, kind, read_site, read_span, pattern_codes, read_count,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/rpmc_out_if.sv */
// rpmc_out_if: valid/ready channel carrying per-site dump results.
// Depends on rpmc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rpmc_out_if;
  logic                            valid;
  logic                            ready;
  logic [rpmc_pkg::IDX_OUT_W-1:0]  site_index;
  logic [rpmc_pkg::OUT_CNT_W-1:0]  meth_count;
  logic [rpmc_pkg::OUT_CNT_W-1:0]  cover_count;
  logic                            last;

  modport source (
    output valid, site_index, meth_count, cover_count, last,
    input  ready
  );
  modport sink (
    input  valid, site_index, meth_count, cover_count, last,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/rpmc_cell.sv */
// rpmc_cell: one window site, holding its methylation and coverage counters.
// Depends on rpmc_pkg; instantiated in a ring by read_pileup_meth_coverage.
`timescale 1ns / 1ps
`default_nettype none

module rpmc_cell #(
  parameter int CounterWidth = 32,
  parameter int CellIdx      = 0
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire rpmc_pkg::rd_bcast_t      rd_i,
  input  wire logic                     in_win_i,
  input  wire logic                     shift_i,
  input  wire logic [CounterWidth-1:0]  meth_nb_i,
  input  wire logic [CounterWidth-1:0]  cover_nb_i,
  output logic      [CounterWidth-1:0]  meth_o,
  output logic      [CounterWidth-1:0]  cover_o
);
  import rpmc_pkg::*;

  localparam int SumW = ((CounterWidth > CNT_IN_W) ? CounterWidth : CNT_IN_W) + 1;
  localparam logic [SumW-1:0] CntMax = SumW'({CounterWidth{1'b1}});

  logic [CounterWidth-1:0] meth_q, meth_d;
  logic [CounterWidth-1:0] cover_q, cover_d;
  logic signed [BASE_W:0]  pos;
  logic [1:0]              code;
  logic                    hit;
  logic [SumW-1:0]         meth_sum, cover_sum;
  logic [CounterWidth-1:0] meth_sat, cover_sat;

  // pattern position that lands on this site
  assign pos  = $signed((BASE_W+1)'(CellIdx)) - $signed({rd_i.base[BASE_W-1], rd_i.base});
  assign code = rd_i.pattern[pos[$clog2(PAT_POS)-1:0]];
  assign hit  = rd_i.valid && in_win_i && !pos[BASE_W] &&
                (pos[BASE_W-1:0] < BASE_W'(rd_i.len)) &&
                ((code == CODE_T) || (code == CODE_C));

  // saturating accumulate
  assign meth_sum  = SumW'(meth_q) + SumW'(rd_i.count);
  assign cover_sum = SumW'(cover_q) + SumW'(rd_i.count);
  assign meth_sat  = (meth_sum > CntMax) ? CntMax[CounterWidth-1:0]
                                         : meth_sum[CounterWidth-1:0];
  assign cover_sat = (cover_sum > CntMax) ? CntMax[CounterWidth-1:0]
                                          : cover_sum[CounterWidth-1:0];

  // ring shift during a dump, otherwise update on a hit
  always_comb begin
    meth_d  = meth_q;
    cover_d = cover_q;
    priority if (shift_i) begin
      meth_d  = meth_nb_i;
      cover_d = cover_nb_i;
    end else if (hit) begin
      cover_d = cover_sat;
      if (code == CODE_C) begin
        meth_d = meth_sat;
      end
    end else begin
      meth_d  = meth_q;
      cover_d = cover_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meth_q  <= '0;
      cover_q <= '0;
    end else begin
      meth_q  <= meth_d;
      cover_q <= cover_d;
    end
  end

  assign meth_o  = meth_q;
  assign cover_o = cover_q;

endmodule

`default_nettype wire

/* hdl/read_pileup_meth_coverage.sv */
// Methylation pileup over a window of CpG sites.
//
// Input channel (in_if): kind 0 is a read, kind 1 a dump. A read is held in
// the input-stage register rd_q, then lands in the counters; reads stream at
// one per cycle while no dump runs. Window offsets and the clamped length are
// worked out in the input stage, then broadcast to a ring of WindowSites cells.
// A dump rotates the ring once around, one site per cycle unless stalled, with
// cell 0 feeding the output register; nsites (window_len clamped to WindowSites)
// results come out, in order, last set on the final one. A dump with an empty
// window gives no results. No item is taken while a dump runs. A stalled
// receiver holds the output register and freezes the ring while results remain.
// Config: cfg_we_i writes first_site (index 0) or window_len (index 1); the user
// must write only while the block is idle, as the block does not enforce it.
// Reset clears both counter arrays and loads first_site 1, window_len 64.
// Depends on rpmc_pkg, rpmc_in_if, rpmc_out_if and rpmc_cell.
`timescale 1ns / 1ps
`default_nettype none

module read_pileup_meth_coverage #(
  parameter int WindowSites  = 64,
  parameter int MaxReadLen   = 32,
  parameter int CounterWidth = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  rpmc_in_if.sink                                 in_if,
  rpmc_out_if.source                              out_if,
  input  wire logic                               cfg_we_i,
  input  wire logic [rpmc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [rpmc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import rpmc_pkg::*;

  localparam int StepW = $clog2(WindowSites + 1);
  localparam logic signed [SITE_W:0] BaseLo = -$signed((SITE_W+1)'(MaxReadLen));
  localparam logic signed [SITE_W:0] BaseHi = $signed((SITE_W+1)'(WindowSites));

  logic [SITE_W-1:0]  first_site_q;
  logic [WLEN_W-1:0]  window_len_q;
  logic [WLEN_W-1:0]  nsites;

  state_e             state_q, state_d;
  logic [StepW-1:0]   step_q, step_d;
  rd_bcast_t          rd_q, rd_d;

  logic signed [SITE_W:0] base_full;
  logic                   in_xfer, shift, emit;

  logic                   out_valid_q, out_valid_d;
  logic [IDX_OUT_W-1:0]   out_idx_q;
  logic [OUT_CNT_W-1:0]   out_meth_q, out_cover_q;
  logic                   out_last_q;
  logic [OUT_CNT_W-1:0]   head_meth, head_cover;

  logic [CounterWidth-1:0] meth_w  [WindowSites];
  logic [CounterWidth-1:0] cover_w [WindowSites];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_site_q <= FIRST_SITE_RST;
      window_len_q <= WINDOW_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FIRST_SITE: first_site_q <= cfg_data_i[SITE_W-1:0];
        CFG_WINDOW_LEN: window_len_q <= cfg_data_i[WLEN_W-1:0];
      endcase
    end
  end

  assign nsites = (window_len_q > WLEN_W'(WindowSites)) ? WLEN_W'(WindowSites)
                                                         : window_len_q;

  // input stage: window offset and clamped length
  assign in_if.ready = (state_q == ST_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign base_full   = $signed({1'b0, in_if.read_site}) - $signed({1'b0, first_site_q});

  always_comb begin
    rd_d         = rd_q;
    rd_d.valid   = in_xfer && !in_if.kind && (base_full > BaseLo) && (base_full < BaseHi);
    rd_d.base    = base_full[BASE_W-1:0];
    rd_d.len     = (in_if.read_span > LEN_W'(MaxReadLen)) ? LEN_W'(MaxReadLen)
                                                           : in_if.read_span;
    rd_d.pattern = in_if.pattern_codes;
    rd_d.count   = in_if.read_count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
    end else begin
      rd_q <= rd_d;
    end
  end

  // ring of site cells, data moves toward cell 0 on a shift
  for (genvar k = 0; k < WindowSites; k++) begin : g_cell
    localparam int Nx = (k + 1) % WindowSites;
    rpmc_cell #(
      .CounterWidth (CounterWidth),
      .CellIdx      (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .rd_i       (rd_q),
      .in_win_i   (WLEN_W'(k) < nsites),
      .shift_i    (shift),
      .meth_nb_i  (meth_w[Nx]),
      .cover_nb_i (cover_w[Nx]),
      .meth_o     (meth_w[k]),
      .cover_o    (cover_w[k])
    );
  end

  // head of the ring, clipped to the output width
  if (CounterWidth > OUT_CNT_W) begin : g_out_sat
    assign head_meth  = (|meth_w[0][CounterWidth-1:OUT_CNT_W]) ? '1
                                                              : meth_w[0][OUT_CNT_W-1:0];
    assign head_cover = (|cover_w[0][CounterWidth-1:OUT_CNT_W]) ? '1
                                                               : cover_w[0][OUT_CNT_W-1:0];
  end else begin : g_out_ext
    assign head_meth  = OUT_CNT_W'(meth_w[0]);
    assign head_cover = OUT_CNT_W'(cover_w[0]);
  end

  // dump sequencer
  assign emit  = (WLEN_W'(step_q) < nsites);
  assign shift = (state_q == ST_DUMP) && !rd_q.valid &&
                 (!emit || !out_valid_q || out_if.ready);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && in_if.kind && (nsites != '0)) begin
          state_d = ST_DUMP;
          step_d  = '0;
        end
      end
      ST_DUMP: begin
        if (shift) begin
          step_d = step_q + StepW'(1);
          if (step_q == StepW'(WindowSites - 1)) begin
            state_d = ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // output register
  assign out_valid_d = (out_valid_q && !out_if.ready) || (shift && emit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift && emit) begin
      out_idx_q   <= IDX_OUT_W'(step_q);
      out_meth_q  <= head_meth;
      out_cover_q <= head_cover;
      out_last_q  <= (WLEN_W'(step_q) + WLEN_W'(1) == nsites);
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.site_index  = out_idx_q;
  assign out_if.meth_count  = out_meth_q;
  assign out_if.cover_count = out_cover_q;
  assign out_if.last        = out_last_q;

`ifndef SYNTHESIS
  // the ring never rotates while a read is still to be applied
  a_no_shift_with_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift |-> !rd_q.valid)
    else $error("ring shifted with a pending read");

  // a new result only appears from a dump
  a_out_from_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DUMP))
    else $error("result outside a dump");

  // a full rotation ends the dump
  a_dump_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (shift && (step_q == StepW'(WindowSites - 1))) |=> (state_q == ST_IDLE))
    else $error("dump did not end after a full rotation");

  // the last flag belongs to the final emitted site
  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (shift && emit && (WLEN_W'(step_q) + WLEN_W'(1) == nsites)) |=> out_last_q)
    else $error("last flag missing on final site");
`endif

endmodule

`default_nettype wire
